// ===== rtl/aosfm_pkg.sv =====
// Shared types, register indexes and command codes for the audio output stage.
// Used by every module of the block; depends on nothing.
`default_nettype none

package aosfm_pkg;

   localparam int SAMPLE_W         = 24;
   localparam int GAIN_W           = 16;
   localparam int LEVEL_W          = 23;
   localparam int MODE_W           = 2;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 23;
   localparam int PEAK_WINDOW_BITS = 9;

   localparam logic [CSR_INDEX_W-1:0] REG_REFLECTION_GAIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESET_GAIN     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_STEP       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_MODE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PEAK_THRESHOLD  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_METER_RATE      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_METER_SCALE     = 3'd6;

   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HALF   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;

   localparam logic [GAIN_W-1:0]  RST_REFLECTION_GAIN = 16'd0;
   localparam logic [GAIN_W-1:0]  RST_PRESET_GAIN     = 16'd32768;
   localparam logic [GAIN_W-1:0]  RST_FADE_STEP       = 16'd328;
   localparam logic [LEVEL_W-1:0] RST_PEAK_THRESHOLD  = 23'd7549747;
   localparam logic [GAIN_W-1:0]  RST_METER_RATE      = 16'd655;
   localparam logic [GAIN_W-1:0]  RST_METER_SCALE     = 16'd32768;

   localparam logic [3:0] MUL_FADE    = 4'd0;
   localparam logic [3:0] MUL_REFL_L  = 4'd1;
   localparam logic [3:0] MUL_REFL_R  = 4'd2;
   localparam logic [3:0] MUL_GAIN_L  = 4'd3;
   localparam logic [3:0] MUL_GAIN_R  = 4'd4;
   localparam logic [3:0] MUL_SCALE_L = 4'd5;
   localparam logic [3:0] MUL_SCALE_R = 4'd6;
   localparam logic [3:0] MUL_RATE_L  = 4'd7;
   localparam logic [3:0] MUL_RATE_R  = 4'd8;

   localparam logic [3:0] POST_NONE      = 4'd0;
   localparam logic [3:0] POST_FADE_GAIN = 4'd1;
   localparam logic [3:0] POST_LEFT      = 4'd2;
   localparam logic [3:0] POST_RIGHT     = 4'd3;
   localparam logic [3:0] POST_OUT_L     = 4'd4;
   localparam logic [3:0] POST_OUT_R     = 4'd5;
   localparam logic [3:0] POST_TGT_L     = 4'd6;
   localparam logic [3:0] POST_TGT_R     = 4'd7;
   localparam logic [3:0] POST_ACC_L     = 4'd8;
   localparam logic [3:0] POST_ACC_R     = 4'd9;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] main_sample;
      logic signed [SAMPLE_W-1:0] reflection_left;
      logic signed [SAMPLE_W-1:0] reflection_right;
      logic                       mute_request;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
      logic                       clip_lamp;
      logic                       fade_settled;
      logic [LEVEL_W-1:0]         level_left;
      logic [LEVEL_W-1:0]         level_right;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  reflection_gain;
      logic [GAIN_W-1:0]  preset_gain;
      logic [GAIN_W-1:0]  fade_step;
      logic [MODE_W-1:0]  output_mode;
      logic [LEVEL_W-1:0] peak_threshold;
      logic [GAIN_W-1:0]  meter_rate;
      logic [GAIN_W-1:0]  meter_scale;
   } cfg_type;

   typedef struct packed {
      logic       load_in;
      logic       mul_en;
      logic [3:0] mul_sel;
      logic [3:0] post_sel;
      logic       load_rsp;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/aosfm_csr.sv =====
// Configuration registers of the audio output stage.
// Depends on aosfm_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module aosfm_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [aosfm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [aosfm_pkg::CSR_DATA_W-1:0]      csr_data,
   output aosfm_pkg::cfg_type                         cfg
);

   aosfm_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reflection_gain <= aosfm_pkg::RST_REFLECTION_GAIN;
         cfg_ff.preset_gain     <= aosfm_pkg::RST_PRESET_GAIN;
         cfg_ff.fade_step       <= aosfm_pkg::RST_FADE_STEP;
         cfg_ff.output_mode     <= aosfm_pkg::MODE_NORMAL;
         cfg_ff.peak_threshold  <= aosfm_pkg::RST_PEAK_THRESHOLD;
         cfg_ff.meter_rate      <= aosfm_pkg::RST_METER_RATE;
         cfg_ff.meter_scale     <= aosfm_pkg::RST_METER_SCALE;
      end else if (csr_write) begin
         case (csr_index)
            aosfm_pkg::REG_REFLECTION_GAIN: begin
               cfg_ff.reflection_gain <= csr_data[aosfm_pkg::GAIN_W-1:0];
            end
            aosfm_pkg::REG_PRESET_GAIN: begin
               cfg_ff.preset_gain <= csr_data[aosfm_pkg::GAIN_W-1:0];
            end
            aosfm_pkg::REG_FADE_STEP: begin
               cfg_ff.fade_step <= csr_data[aosfm_pkg::GAIN_W-1:0];
            end
            aosfm_pkg::REG_OUTPUT_MODE: begin
               cfg_ff.output_mode <= csr_data[aosfm_pkg::MODE_W-1:0];
            end
            aosfm_pkg::REG_PEAK_THRESHOLD: begin
               cfg_ff.peak_threshold <= csr_data[aosfm_pkg::LEVEL_W-1:0];
            end
            aosfm_pkg::REG_METER_RATE: begin
               cfg_ff.meter_rate <= csr_data[aosfm_pkg::GAIN_W-1:0];
            end
            aosfm_pkg::REG_METER_SCALE: begin
               cfg_ff.meter_scale <= csr_data[aosfm_pkg::GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/aosfm_ctrl.sv =====
// Sequencer of the audio output stage: steps the shared multiplier through
// one frame and owns both handshakes. Depends on aosfm_pkg for cmd_type and codes.
`default_nettype none

module aosfm_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output aosfm_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_FADE    = 4'd1;
   localparam logic [3:0] ST_REFL_L  = 4'd2;
   localparam logic [3:0] ST_REFL_R  = 4'd3;
   localparam logic [3:0] ST_GAIN_L  = 4'd4;
   localparam logic [3:0] ST_GAIN_R  = 4'd5;
   localparam logic [3:0] ST_SCALE_L = 4'd6;
   localparam logic [3:0] ST_SCALE_R = 4'd7;
   localparam logic [3:0] ST_RATE_L  = 4'd8;
   localparam logic [3:0] ST_RATE_R  = 4'd9;
   localparam logic [3:0] ST_FINISH  = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = aosfm_pkg::MUL_FADE;
      cmd.post_sel = aosfm_pkg::POST_NONE;
      state_in     = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_in = req_valid;
            if (req_valid) begin
               state_in = ST_FADE;
            end
         end
         ST_FADE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = aosfm_pkg::MUL_FADE;
            state_in    = ST_REFL_L;
         end
         ST_REFL_L: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = aosfm_pkg::MUL_REFL_L;
            cmd.post_sel = aosfm_pkg::POST_FADE_GAIN;
            state_in     = ST_REFL_R;
         end
         ST_REFL_R: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = aosfm_pkg::MUL_REFL_R;
            cmd.post_sel = aosfm_pkg::POST_LEFT;
            state_in     = ST_GAIN_L;
         end
         ST_GAIN_L: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = aosfm_pkg::MUL_GAIN_L;
            cmd.post_sel = aosfm_pkg::POST_RIGHT;
            state_in     = ST_GAIN_R;
         end
         ST_GAIN_R: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = aosfm_pkg::MUL_GAIN_R;
            cmd.post_sel = aosfm_pkg::POST_OUT_L;
            state_in     = ST_SCALE_L;
         end
         ST_SCALE_L: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = aosfm_pkg::MUL_SCALE_L;
            cmd.post_sel = aosfm_pkg::POST_OUT_R;
            state_in     = ST_SCALE_R;
         end
         ST_SCALE_R: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = aosfm_pkg::MUL_SCALE_R;
            cmd.post_sel = aosfm_pkg::POST_TGT_L;
            state_in     = ST_RATE_L;
         end
         ST_RATE_L: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = aosfm_pkg::MUL_RATE_L;
            cmd.post_sel = aosfm_pkg::POST_TGT_R;
            state_in     = ST_RATE_R;
         end
         ST_RATE_R: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = aosfm_pkg::MUL_RATE_R;
            cmd.post_sel = aosfm_pkg::POST_ACC_L;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.post_sel = aosfm_pkg::POST_ACC_R;
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/aosfm_dp.sv =====
// Datapath of the audio output stage: input and fade registers, one shared
// multiplier, rounding and saturation, peak window, meters and the output register.
// Depends on aosfm_pkg; driven by the command struct of aosfm_ctrl.
`default_nettype none

module aosfm_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire aosfm_pkg::cfg_type cfg,
   input  wire aosfm_pkg::cmd_type cmd,
   input  wire aosfm_pkg::req_type req_data,
   output aosfm_pkg::rsp_type      rsp_data
);

   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int MIX_W   = 26;
   localparam int VAL_W   = 29;
   localparam int ACC_W   = 24;
   localparam int WB      = aosfm_pkg::PEAK_WINDOW_BITS;

   localparam logic [aosfm_pkg::GAIN_W-1:0]  UNITY     = 16'd32768;
   localparam logic [aosfm_pkg::LEVEL_W-1:0] LEVEL_MAX = 23'h7FFFFF;
   localparam logic [ACC_W-1:0]              ACC_MAX   = 24'hFFFFFF;

   function automatic logic signed [aosfm_pkg::SAMPLE_W-1:0] sat24(
      input logic signed [VAL_W-1:0] v);
      logic signed [aosfm_pkg::SAMPLE_W-1:0] r;
      if (v > 29'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -29'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[aosfm_pkg::SAMPLE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [aosfm_pkg::SAMPLE_W-1:0] abs24(
      input logic signed [aosfm_pkg::SAMPLE_W-1:0] v);
      logic [aosfm_pkg::SAMPLE_W-1:0] r;
      r = v[aosfm_pkg::SAMPLE_W-1] ? aosfm_pkg::SAMPLE_W'(-v) : v;
      return r;
   endfunction

   function automatic logic [aosfm_pkg::LEVEL_W-1:0] level_of(input logic [ACC_W-1:0] a);
      logic [aosfm_pkg::LEVEL_W-1:0] r;
      r = (a > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : a[aosfm_pkg::LEVEL_W-1:0];
      return r;
   endfunction

   aosfm_pkg::req_type               in_ff;
   logic [aosfm_pkg::GAIN_W-1:0]     fade_ff;
   logic [aosfm_pkg::GAIN_W-1:0]     fade_in;
   logic                             settled_ff;
   logic                             settled_in;
   logic signed [PROD_W-1:0]         product_ff;
   logic signed [PROD_W-1:0]         product_in;
   logic [31:0]                      g_ff;
   logic signed [MIX_W-1:0]          left_ff;
   logic signed [MIX_W-1:0]          right_ff;
   logic signed [VAL_W-1:0]          vl_raw_ff;
   logic signed [aosfm_pkg::SAMPLE_W-1:0] ol_ff;
   logic signed [aosfm_pkg::SAMPLE_W-1:0] or_ff;
   logic signed [aosfm_pkg::SAMPLE_W-1:0] ol_in;
   logic signed [aosfm_pkg::SAMPLE_W-1:0] or_in;
   logic [ACC_W-1:0]                 tl_ff;
   logic [ACC_W-1:0]                 tr_ff;
   logic [ACC_W-1:0]                 tgt_in;
   logic [ACC_W-1:0]                 accl_ff;
   logic [ACC_W-1:0]                 accr_ff;
   logic [ACC_W-1:0]                 acc_in;
   logic [aosfm_pkg::LEVEL_W-1:0]    peak_ff;
   logic [aosfm_pkg::LEVEL_W-1:0]    peak_in;
   logic [WB-1:0]                    count_ff;
   logic [WB-1:0]                    count_in;
   logic                             lamp_ff;
   logic                             lamp_in;
   aosfm_pkg::rsp_type               rsp_ff;

   logic [aosfm_pkg::GAIN_W:0]       fade_sum;
   logic signed [MUL_A_W-1:0]        mul_a;
   logic signed [MUL_B_W-1:0]        mul_b;
   logic signed [ACC_W:0]            diff_l;
   logic signed [ACC_W:0]            diff_r;
   logic signed [PROD_W-1:0]         rnd15;
   logic signed [PROD_W-1:0]         rnd16;
   logic signed [PROD_W-1:0]         rnd30;
   logic signed [MIX_W-1:0]          mix_in;
   logic signed [VAL_W-1:0]          neg30;
   logic signed [VAL_W-1:0]          scaled;
   logic signed [MIX_W-1:0]          abs_left;
   logic [aosfm_pkg::LEVEL_W-1:0]    peak_sample;
   logic [aosfm_pkg::LEVEL_W-1:0]    peak_max;
   logic [ACC_W-1:0]                 acc_sel;
   logic signed [MIX_W-1:0]          acc_sum;

   // fade ramp, taken when an item is accepted
   always_comb begin
      fade_sum   = {1'b0, fade_ff} + {1'b0, cfg.fade_step};
      fade_in    = fade_ff;
      settled_in = 1'b0;
      if (req_data.mute_request) begin
         if (fade_ff != '0) begin
            fade_in = (fade_ff > cfg.fade_step) ? fade_ff - cfg.fade_step : '0;
         end else begin
            fade_in    = '0;
            settled_in = 1'b1;
         end
      end else begin
         if (fade_ff < UNITY) begin
            fade_in = (fade_sum > {1'b0, UNITY}) ? UNITY : fade_sum[aosfm_pkg::GAIN_W-1:0];
         end else begin
            fade_in    = UNITY;
            settled_in = 1'b1;
         end
      end
   end

   assign diff_l = $signed({1'b0, tl_ff}) - $signed({1'b0, accl_ff});
   assign diff_r = $signed({1'b0, tr_ff}) - $signed({1'b0, accr_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         aosfm_pkg::MUL_FADE: begin
            mul_a = $signed({11'b0, fade_ff});
            mul_b = $signed({17'b0, cfg.preset_gain});
         end
         aosfm_pkg::MUL_REFL_L: begin
            mul_a = {{3{in_ff.reflection_left[23]}}, in_ff.reflection_left};
            mul_b = $signed({17'b0, cfg.reflection_gain});
         end
         aosfm_pkg::MUL_REFL_R: begin
            mul_a = {{3{in_ff.reflection_right[23]}}, in_ff.reflection_right};
            mul_b = $signed({17'b0, cfg.reflection_gain});
         end
         aosfm_pkg::MUL_GAIN_L: begin
            mul_a = {left_ff[MIX_W-1], left_ff};
            mul_b = $signed({1'b0, g_ff});
         end
         aosfm_pkg::MUL_GAIN_R: begin
            mul_a = {right_ff[MIX_W-1], right_ff};
            mul_b = $signed({1'b0, g_ff});
         end
         aosfm_pkg::MUL_SCALE_L: begin
            mul_a = $signed({3'b0, abs24(ol_ff)});
            mul_b = $signed({17'b0, cfg.meter_scale});
         end
         aosfm_pkg::MUL_SCALE_R: begin
            mul_a = $signed({3'b0, abs24(or_ff)});
            mul_b = $signed({17'b0, cfg.meter_scale});
         end
         aosfm_pkg::MUL_RATE_L: begin
            mul_a = {{2{diff_l[ACC_W]}}, diff_l};
            mul_b = $signed({17'b0, cfg.meter_rate});
         end
         aosfm_pkg::MUL_RATE_R: begin
            mul_a = {{2{diff_r[ACC_W]}}, diff_r};
            mul_b = $signed({17'b0, cfg.meter_rate});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product_in = mul_a * mul_b;

   assign rnd15 = (product_ff + 60'sd16384) >>> 15;
   assign rnd16 = (product_ff + 60'sd32768) >>> 16;
   assign rnd30 = (product_ff + 60'sd536870912) >>> 30;

   assign mix_in = {{2{in_ff.main_sample[23]}}, in_ff.main_sample} + rnd15[MIX_W-1:0];
   assign neg30  = -$signed(rnd30[VAL_W-1:0]);
   assign scaled = (cfg.output_mode == aosfm_pkg::MODE_HALF) ? (neg30 >>> 1) : neg30;
   assign ol_in  = sat24(scaled);
   assign or_in  = (cfg.output_mode == aosfm_pkg::MODE_MIRROR) ? sat24(-vl_raw_ff)
                                                               : sat24(scaled);

   assign tgt_in = (rnd15 > 60'sd16777215) ? ACC_MAX : rnd15[ACC_W-1:0];

   assign acc_sel = (cmd.post_sel == aosfm_pkg::POST_ACC_R) ? accr_ff : accl_ff;
   assign acc_sum = $signed({2'b0, acc_sel}) + rnd16[MIX_W-1:0];
   always_comb begin
      if (acc_sum < 0) begin
         acc_in = '0;
      end else if (acc_sum > $signed({2'b0, ACC_MAX})) begin
         acc_in = ACC_MAX;
      end else begin
         acc_in = acc_sum[ACC_W-1:0];
      end
   end

   // peak window over the mixed left channel
   assign abs_left    = left_ff[MIX_W-1] ? -left_ff : left_ff;
   assign peak_sample = (abs_left > $signed({3'b0, LEVEL_MAX})) ? LEVEL_MAX
                                                               : abs_left[aosfm_pkg::LEVEL_W-1:0];
   assign peak_max    = (peak_sample > peak_ff) ? peak_sample : peak_ff;
   assign count_in    = count_ff + 1'b1;
   always_comb begin
      lamp_in = lamp_ff;
      peak_in = peak_max;
      if (count_in == '0) begin
         lamp_in = (peak_max > cfg.peak_threshold);
         peak_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff  <= '0;
         peak_ff  <= '0;
         count_ff <= '0;
         lamp_ff  <= 1'b0;
         accl_ff  <= '0;
         accr_ff  <= '0;
      end else begin
         if (cmd.load_in) begin
            fade_ff <= fade_in;
         end
         if (cmd.post_sel == aosfm_pkg::POST_RIGHT) begin
            peak_ff  <= peak_in;
            count_ff <= count_in;
            lamp_ff  <= lamp_in;
         end
         if (cmd.post_sel == aosfm_pkg::POST_ACC_L) begin
            accl_ff <= acc_in;
         end
         if (cmd.post_sel == aosfm_pkg::POST_ACC_R) begin
            accr_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff      <= req_data;
         settled_ff <= settled_in;
      end
      if (cmd.mul_en) begin
         product_ff <= product_in;
      end
      case (cmd.post_sel)
         aosfm_pkg::POST_FADE_GAIN: begin
            g_ff <= product_ff[31:0];
         end
         aosfm_pkg::POST_LEFT: begin
            left_ff <= mix_in;
         end
         aosfm_pkg::POST_RIGHT: begin
            right_ff <= mix_in;
         end
         aosfm_pkg::POST_OUT_L: begin
            vl_raw_ff <= neg30;
            ol_ff     <= ol_in;
         end
         aosfm_pkg::POST_OUT_R: begin
            or_ff <= or_in;
         end
         aosfm_pkg::POST_TGT_L: begin
            tl_ff <= tgt_in;
         end
         aosfm_pkg::POST_TGT_R: begin
            tr_ff <= tgt_in;
         end
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_ff.out_left     <= ol_ff;
         rsp_ff.out_right    <= or_ff;
         rsp_ff.clip_lamp    <= lamp_ff;
         rsp_ff.fade_settled <= settled_ff;
         rsp_ff.level_left   <= level_of(accl_ff);
         rsp_ff.level_right  <= level_of(acc_in);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/audio_output_stage_fade_meter.sv =====
// Audio output stage: reflection mix, clip lamp, mute fade, preset gain,
// polarity, channel mode, 24-bit saturation and two smoothed level meters.
//
// Input channel req_*: one frame per item (mono sample, two reflection samples,
// mute request), taken when req_valid is high and req_stall is low.
// Result channel rsp_*: one item per input item, in order, held in an output
// register while rsp_stall is high.
// Configuration: csr_write with csr_index and csr_data, written while idle.
//
// A single 27x33 multiplier forms the nine products of a frame (fade gain,
// two mixes, two gains, two meter scales, two meter steps), one per cycle,
// followed by a finishing step for the last rounding and output load and an
// idle step in which the next item is taken; no new item is taken before
// the frame is finished.
// The next item is taken while a finished result still waits; if the previous
// result has not been taken by then, the frame holds in its last step.
// Reset clears the fade gain, peak window, lamp and meters and loads the
// register defaults; no result is pending after reset.
// Depends on aosfm_pkg, aosfm_csr, aosfm_ctrl and aosfm_dp.
`default_nettype none

module audio_output_stage_fade_meter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire aosfm_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output aosfm_pkg::rsp_type                     rsp_data,
   input  wire logic                              csr_write,
   input  wire logic [aosfm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [aosfm_pkg::CSR_DATA_W-1:0]  csr_data
);

   aosfm_pkg::cfg_type cfg;
   aosfm_pkg::cmd_type cmd;

   aosfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   aosfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   aosfm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took a second item while working on one");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || !rsp_stall))
      else $error("pending result overwritten");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("loaded result not presented");

   a_load_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (req_stall && !cmd.load_in))
      else $error("result loaded outside a frame");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for audio_output_stage_fade_meter: directed and random frames,
// checked field by field against an in-bench fixed-point predictor of the output stage.
// Depends on aosfm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
   import aosfm_pkg::*;

   localparam int              SETTLE_CYCLES = 16;
   localparam int              HOLD_CYCLES   = 200;
   localparam int              WATCHDOG_MAX  = 4000;
   localparam int              UNITY         = 32768;
   localparam longint          OUT_MAX       = 8388607;
   localparam longint          OUT_MIN       = -8388608;
   localparam longint          METER_MAX     = 16777215;
   localparam logic [MODE_W-1:0]      MODE_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED  = 3'd7;
   localparam logic signed [SAMPLE_W-1:0] FULL_POS = 24'sh7fffff;
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 24'sh800000;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   logic                   hold_req  = 1'b0;

   audio_output_stage_fade_meter uut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data,
      .csr_write, .csr_index, .csr_data
   );

   // predictor state and register copy
   cfg_type regs;
   int      fade_level;
   longint  peak_hold;
   int      window_pos;
   logic    lamp_on;
   longint  meter_l, meter_r;

   rsp_type pending[$];
   bit      idle_on = 1'b1;
   int      fail_count, frames_sent, results_checked, reg_writes;
   int      idle_cycles, hold_left, rsp_wait;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_shr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint sat_sample(longint v);
      return v > OUT_MAX ? OUT_MAX : (v < OUT_MIN ? OUT_MIN : v);
   endfunction

   function automatic longint meter_next(longint acc, longint outv);
      longint target, a;
      target = round_shr(mag(outv) * longint'(regs.meter_scale), 15);
      if (target > METER_MAX) target = METER_MAX;
      a = acc + round_shr(longint'(regs.meter_rate) * (target - acc), 16);
      if (a < 0) a = 0;
      if (a > METER_MAX) a = METER_MAX;
      return a;
   endfunction

   function automatic rsp_type predict_output_frame(req_type f);
      longint  m, rl, rr, left, right, pk, g, ol, orr;
      logic    settled;
      rsp_type r;
      m  = longint'(f.main_sample);
      rl = longint'(f.reflection_left);
      rr = longint'(f.reflection_right);
      settled = 1'b0;
      left  = m + round_shr(rl * longint'(regs.reflection_gain), 15);
      right = m + round_shr(rr * longint'(regs.reflection_gain), 15);

      pk = mag(left);
      if (pk > OUT_MAX) pk = OUT_MAX;
      if (pk > peak_hold) peak_hold = pk;
      window_pos = (window_pos + 1) & ((1 << PEAK_WINDOW_BITS) - 1);
      if (window_pos == 0) begin
         lamp_on = peak_hold > longint'(regs.peak_threshold);
         peak_hold = 0;
      end

      if (f.mute_request) begin
         if (fade_level > 0)
            fade_level = (fade_level > int'(regs.fade_step)) ? fade_level - int'(regs.fade_step) : 0;
         else
            settled = 1'b1;
      end else begin
         if (fade_level < UNITY) begin
            fade_level += int'(regs.fade_step);
            if (fade_level > UNITY) fade_level = UNITY;
         end else begin
            fade_level = UNITY;
            settled = 1'b1;
         end
      end

      g   = longint'(regs.preset_gain) * longint'(fade_level);
      ol  = -round_shr(left * g, 30);
      orr = -round_shr(right * g, 30);
      if (regs.output_mode == MODE_HALF) begin
         ol  = ol >>> 1;
         orr = orr >>> 1;
      end else if (regs.output_mode == MODE_MIRROR) begin
         orr = -ol;
      end
      ol  = sat_sample(ol);
      orr = sat_sample(orr);
      meter_l = meter_next(meter_l, ol);
      meter_r = meter_next(meter_r, orr);

      r.out_left     = ol[SAMPLE_W-1:0];
      r.out_right    = orr[SAMPLE_W-1:0];
      r.clip_lamp    = lamp_on;
      r.fade_settled = settled;
      r.level_left   = meter_l > OUT_MAX ? OUT_MAX[LEVEL_W-1:0] : meter_l[LEVEL_W-1:0];
      r.level_right  = meter_r > OUT_MAX ? OUT_MAX[LEVEL_W-1:0] : meter_r[LEVEL_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // check each result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            $error("result item arrived with no prediction pending");
            fail_count++;
         end else begin
            rsp_type want;
            want = pending.pop_front();
            check_field("out_left", 64'(want.out_left), 64'(rsp_data.out_left));
            check_field("out_right", 64'(want.out_right), 64'(rsp_data.out_right));
            check_field("clip_lamp", 64'(want.clip_lamp), 64'(rsp_data.clip_lamp));
            check_field("fade_settled", 64'(want.fade_settled), 64'(rsp_data.fade_settled));
            check_field("level_left", 64'(want.level_left), 64'(rsp_data.level_left));
            check_field("level_right", 64'(want.level_right), 64'(rsp_data.level_right));
         end
         results_checked++;
      end
   end

   // receiver: random stall after each item while idle_on is set, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         rsp_wait  = 0;
      end else begin
         if (hold_req) hold_left = HOLD_CYCLES;
         if (rsp_valid && !rsp_stall) rsp_wait = idle_on ? $urandom_range(0, 4) : 0;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("audio_output_stage_fade_meter test failed");
            $finish;
         end
      end
   end

   task automatic send_frame(input req_type f);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending.push_back(predict_output_frame(f));
      frames_sent++;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         REG_REFLECTION_GAIN: regs.reflection_gain = val[GAIN_W-1:0];
         REG_PRESET_GAIN:     regs.preset_gain     = val[GAIN_W-1:0];
         REG_FADE_STEP:       regs.fade_step       = val[GAIN_W-1:0];
         REG_OUTPUT_MODE:     regs.output_mode     = val[MODE_W-1:0];
         REG_PEAK_THRESHOLD:  regs.peak_threshold  = val[LEVEL_W-1:0];
         REG_METER_RATE:      regs.meter_rate      = val[GAIN_W-1:0];
         REG_METER_SCALE:     regs.meter_scale     = val[GAIN_W-1:0];
         default: ;
      endcase
      csr_write <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   task automatic load_settings(input cfg_type c);
      write_reg(REG_REFLECTION_GAIN, CSR_DATA_W'(c.reflection_gain));
      write_reg(REG_PRESET_GAIN, CSR_DATA_W'(c.preset_gain));
      write_reg(REG_FADE_STEP, CSR_DATA_W'(c.fade_step));
      write_reg(REG_OUTPUT_MODE, CSR_DATA_W'(c.output_mode));
      write_reg(REG_PEAK_THRESHOLD, c.peak_threshold);
      write_reg(REG_METER_RATE, CSR_DATA_W'(c.meter_rate));
      write_reg(REG_METER_SCALE, CSR_DATA_W'(c.meter_scale));
   endtask

   function automatic req_type pack_frame(logic signed [SAMPLE_W-1:0] m,
                                          logic signed [SAMPLE_W-1:0] rl,
                                          logic signed [SAMPLE_W-1:0] rr, logic mute);
      req_type f;
      f.main_sample      = m;
      f.reflection_left  = rl;
      f.reflection_right = rr;
      f.mute_request     = mute;
      return f;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return FULL_POS;
         1:       return FULL_NEG;
         2:       return '0;
         3:       return SAMPLE_W'($urandom_range(0, 511)) - 24'sd256;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      return ($urandom_range(0, 7) == 0) ? 16'hffff : GAIN_W'($urandom_range(0, UNITY));
   endfunction

   function automatic cfg_type pick_settings(int ph);
      cfg_type c;
      if (ph == 0) begin
         c = '{reflection_gain: '0, preset_gain: '0, fade_step: 16'd1, output_mode: MODE_NORMAL,
               peak_threshold: '0, meter_rate: '0, meter_scale: '0};
      end else if (ph == 1) begin
         c = '{reflection_gain: 16'd32768, preset_gain: 16'd32768, fade_step: 16'd32768,
               output_mode: MODE_MIRROR, peak_threshold: 23'h7fffff, meter_rate: 16'hffff,
               meter_scale: 16'd32768};
      end else begin
         c.reflection_gain = rand_gain();
         c.preset_gain     = rand_gain();
         c.fade_step       = GAIN_W'($urandom_range(1, 4000));
         c.output_mode     = MODE_W'($urandom_range(0, 3));
         c.peak_threshold  = LEVEL_W'($urandom_range(0, 8388607));
         c.meter_rate      = GAIN_W'($urandom_range(0, 65535));
         c.meter_scale     = rand_gain();
      end
      return c;
   endfunction

   task automatic test_full_scale();
      settle_block();
      write_reg(REG_REFLECTION_GAIN, 23'd32768);
      write_reg(REG_PRESET_GAIN, 23'd32768);
      write_reg(REG_FADE_STEP, 23'd32768);
      write_reg(REG_METER_RATE, 23'd65535);
      send_frame(pack_frame('0, '0, '0, 1'b0));
      send_frame(pack_frame(FULL_POS, FULL_POS, FULL_POS, 1'b0));
      send_frame(pack_frame(FULL_NEG, FULL_NEG, FULL_NEG, 1'b0));
      send_frame(pack_frame(FULL_NEG, '0, '0, 1'b0));
      send_frame(pack_frame(24'sh555555, 24'shaaaaaa, 24'shffffff, 1'b0));
      settle_block();
      write_reg(REG_REFLECTION_GAIN, 23'd65535);
      write_reg(REG_PRESET_GAIN, 23'd65535);
      send_frame(pack_frame(24'sh400000, FULL_POS, FULL_NEG, 1'b0));
      send_frame(pack_frame(24'shaaaaaa, 24'sh555555, 24'sh000001, 1'b1));
      send_frame(pack_frame(24'sh123456, 24'sh654321, 24'shfedcba, 1'b1));
   endtask

   task automatic test_output_modes();
      logic [MODE_W-1:0] modes [4] = '{MODE_NORMAL, MODE_HALF, MODE_MIRROR, MODE_UNUSED};
      settle_block();
      write_reg(REG_PRESET_GAIN, 23'd32768);
      write_reg(REG_REFLECTION_GAIN, 23'd16384);
      foreach (modes[i]) begin
         settle_block();
         write_reg(REG_OUTPUT_MODE, CSR_DATA_W'(modes[i]));
         send_frame(pack_frame(24'sd12345, 24'sd3, -24'sd5, 1'b0));
         send_frame(pack_frame(-24'sd77777, FULL_NEG, FULL_POS, 1'b0));
      end
   endtask

   task automatic test_fade_step_edges();
      settle_block();
      write_reg(REG_OUTPUT_MODE, CSR_DATA_W'(MODE_NORMAL));
      write_reg(REG_FADE_STEP, '0);
      send_frame(pack_frame(24'sd100000, '0, '0, 1'b1));
      send_frame(pack_frame(-24'sd100000, '0, '0, 1'b1));
      send_frame(pack_frame(24'sd4242, '0, '0, 1'b0));
      settle_block();
      write_reg(REG_FADE_STEP, 23'd65535);
      send_frame(pack_frame(24'sd99999, 24'sd1, 24'sd1, 1'b1));
      send_frame(pack_frame(24'sd99999, 24'sd1, 24'sd1, 1'b1));
      send_frame(pack_frame(24'sd99999, 24'sd1, 24'sd1, 1'b0));
   endtask

   task automatic test_unused_index();
      settle_block();
      write_reg(REG_UNUSED, '1);
      send_frame(pack_frame(24'sh3c3c3c, 24'shc3c3c3, 24'sh0f0f0f, 1'b0));
   endtask

   // long mute and unmute runs so the fade reaches both limits, with short runs as noise
   task automatic test_random_traffic();
      bit mute;
      int run;
      mute = 1'b0;
      run  = 0;
      for (int ph = 0; ph < 5; ph++) begin
         settle_block();
         load_settings(pick_settings(ph));
         for (int n = 0; n < 100; n++) begin
            if (n % 37 == 0) idle_on = $urandom_range(0, 3) != 0;
            if (run == 0) begin
               mute = 1'($urandom_range(0, 1));
               run  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(20, 150);
            end
            run--;
            send_frame(pack_frame(rand_sample(), rand_sample(), rand_sample(), mute));
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      settle_block();
      idle_on = 1'b0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (12) send_frame(pack_frame(rand_sample(), rand_sample(), rand_sample(), 1'b0));
      idle_on = 1'b1;
   endtask

   initial begin
      regs = '{reflection_gain: RST_REFLECTION_GAIN, preset_gain: RST_PRESET_GAIN,
               fade_step: RST_FADE_STEP, output_mode: MODE_NORMAL,
               peak_threshold: RST_PEAK_THRESHOLD, meter_rate: RST_METER_RATE,
               meter_scale: RST_METER_SCALE};
      fade_level = 0;
      peak_hold  = 0;
      window_pos = 0;
      lamp_on    = 1'b0;
      meter_l    = 0;
      meter_r    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_full_scale();
      test_output_modes();
      test_fade_step_edges();
      test_unused_index();
      test_random_traffic();
      test_output_backpressure();

      settle_block();
      $display("Sent %0d frames and checked %0d results over %0d register writes,", frames_sent,
               results_checked, reg_writes);
      $display("covering all output modes, fade limits, gain extremes and output hold-off.");
      if (fail_count == 0)
         $display("audio_output_stage_fade_meter test passed");
      else
         $display("audio_output_stage_fade_meter test failed");
      $finish;
   end

endmodule
